>>> hdl/kpec_pkg.sv
// Types and constants shared by the key press event classifier.
package kpec_pkg;

    localparam logic [1:0] CLS_RELEASE = 2'd0;
    localparam logic [1:0] CLS_CLICK   = 2'd1;
    localparam logic [1:0] CLS_KEEP    = 2'd2;
    localparam logic [1:0] CLS_LONG    = 2'd3;

    localparam logic CFG_LONG_PRESS_TIME = 1'b0;
    localparam logic CFG_NOTIFY_ENABLE   = 1'b1;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [2:0]  key_index;
        logic        key_level;
        logic [31:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic [2:0] key_echo;
        logic       rising_edge;
        logic       falling_edge;
        logic       toggle_state;
        logic [1:0] event_class;
        logic       report_press;
        logic       report_long;
        logic       report_release;
    } t_out_item;

    typedef struct packed {
        logic        level;
        logic        toggle;
        logic [31:0] press_time;
        logic [1:0]  cls;
    } t_key_rec;

    typedef struct packed {
        logic        key_ok;
        logic        notify_en;
        logic [15:0] long_press_time;
    } t_upd_ctl;

endpackage

>>> hdl/key_press_event_classifier.sv
// Top level of the key press event classifier: record memory and pipeline.
//
// Usage: each input item is one sample of one key (index, level, ms tick).
// The block answers every accepted item with exactly one result item, in
// order. Both channels use valid/stall; an item moves on a clock edge with
// valid high and stall low.
// The memory read happens at the edge that accepts an item; the update result
// is then registered in the output register, which presents it.
// Throughput: one item per cycle while the receiver does not stall. Samples
// of the same key may follow each other back to back; the record written by
// the previous item is forwarded around the registered memory read.
// Per-key records sit in one synchronous memory of NUM_KEYS entries; per-entry
// valid bits make unwritten entries read as the reset record, so no clearing
// pass is needed and items are taken from the first cycle after reset.
// Reset (synchronous, active low) empties the pipeline, restores
// long_press_time to 500 and notify_enable to 0.
// When the receiver stalls, the output register holds its item; the input
// stalls in the same cycle if the update stage holds an item too, otherwise
// one more item enters the update stage first.
module key_press_event_classifier #(
    parameter int NUM_KEYS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [kpec_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  kpec_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output kpec_pkg::t_out_item                 o_out_data
);
    import kpec_pkg::*;

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [15:0]         r_long_press_time;
    logic [7:0]          r_notify_enable;

    t_key_rec            mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_ent_valid;

    logic                r_s1_valid;
    t_in_item            r_s1_item;
    logic                r_s1_ok;
    logic [AW-1:0]       r_s1_addr;
    t_key_rec            r_rd_rec;
    logic                r_rd_vld;
    logic                r_fwd_hit;
    t_key_rec            r_fwd_rec;

    logic                r_out_valid;
    t_out_item           r_out_item;

    logic [63:0]         in_idx_wide;
    logic [AW-1:0]       rd_addr;
    logic                in_ok;
    logic                s1_adv;
    logic                load_s1;
    logic                in_accept;
    logic                wr_en;
    t_key_rec            cur_rec;
    t_key_rec            new_rec;
    t_out_item           result;
    t_upd_ctl            upd_ctl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_time <= 16'd500;
            r_notify_enable   <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LONG_PRESS_TIME: r_long_press_time <= i_cfg_data;
                CFG_NOTIFY_ENABLE:   r_notify_enable   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        in_idx_wide = 64'(i_in_data.key_index);
        rd_addr     = in_idx_wide[AW-1:0];
        in_ok       = 32'(i_in_data.key_index) < 32'(NUM_KEYS);
        s1_adv      = !r_out_valid || !i_out_stall;
        load_s1     = !r_s1_valid || s1_adv;
        in_accept   = i_in_valid && load_s1;
        wr_en       = r_s1_valid && r_s1_ok && s1_adv;
        o_in_stall  = !load_s1;
    end

    // record seen by the update: forwarded write, stored entry or reset record
    always_comb begin
        if (r_fwd_hit) begin
            cur_rec = r_fwd_rec;
        end else if (r_rd_vld) begin
            cur_rec = r_rd_rec;
        end else begin
            cur_rec = '0;
        end
        upd_ctl.key_ok          = r_s1_ok;
        upd_ctl.notify_en       = r_notify_enable[r_s1_item.key_index];
        upd_ctl.long_press_time = r_long_press_time;
    end

    kpec_update u_update (
        .i_item   (r_s1_item),
        .i_rec    (cur_rec),
        .i_ctl    (upd_ctl),
        .o_rec    (new_rec),
        .o_result (result)
    );

    // record memory: write port and registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1_addr] <= new_rec;
        end
        if (in_accept) begin
            r_rd_rec <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
        end else if (wr_en) begin
            r_ent_valid[r_s1_addr] <= 1'b1;
        end
    end

    // update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load_s1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_data;
            r_s1_ok   <= in_ok;
            r_s1_addr <= rd_addr;
            r_rd_vld  <= in_ok && r_ent_valid[rd_addr];
            // same-key write at this edge is missed by the read
            r_fwd_hit <= wr_en && (r_s1_addr == rd_addr);
            r_fwd_rec <= new_rec;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

>>> hdl/kpec_update.sv
// Per-key record update: edge detection, toggle, hold timing and event class.
module kpec_update (
    input  kpec_pkg::t_in_item  i_item,
    input  kpec_pkg::t_key_rec  i_rec,
    input  kpec_pkg::t_upd_ctl  i_ctl,
    output kpec_pkg::t_key_rec  o_rec,
    output kpec_pkg::t_out_item o_result
);
    import kpec_pkg::*;

    logic        now;
    logic        rise;
    logic        fall;
    logic        tog;
    logic [31:0] press_t;
    logic [31:0] hold;
    logic        is_long;
    logic [1:0]  cls;
    logic [1:0]  cls_final;

    always_comb begin
        now     = i_item.key_level;
        rise    = now && !i_rec.level;
        fall    = !now && i_rec.level;
        tog     = rise ? ~i_rec.toggle : i_rec.toggle;
        press_t = rise ? i_item.time_now : i_rec.press_time;
        // wrapping difference; zero on a press
        hold    = i_item.time_now - press_t;
        is_long = hold >= {16'd0, i_ctl.long_press_time};

        cls = i_rec.cls;
        if (rise) begin
            cls = tog ? CLS_KEEP : CLS_CLICK;
        end
        if (fall) begin
            cls = is_long ? CLS_LONG : CLS_CLICK;
        end
        if (now && is_long) begin
            cls = CLS_LONG;
        end
        cls_final = now ? cls : CLS_RELEASE;

        o_rec.level      = now;
        o_rec.toggle     = tog;
        o_rec.press_time = press_t;
        o_rec.cls        = cls_final;

        o_result = '0;
        o_result.key_echo = i_item.key_index;
        if (i_ctl.key_ok) begin
            o_result.rising_edge    = rise;
            o_result.falling_edge   = fall;
            o_result.toggle_state   = tog;
            o_result.event_class    = cls_final;
            o_result.report_press   = i_ctl.notify_en && rise;
            // long report looks at the class before a release clears it
            o_result.report_long    = i_ctl.notify_en && !rise && (cls == CLS_LONG);
            o_result.report_release = i_ctl.notify_en && fall;
        end
    end

endmodule

>>> verif/key_press_event_classifier_test.sv
// Self-checking testbench for the key press event classifier: directed and random key samples.
module key_press_event_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kpec_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int N_KEYS     = 8;

    // Per-key event predictor plus the queue of events still owed by the block
    class key_event_checker;
        logic        level_q [N_KEYS];
        logic        toggle_q[N_KEYS];
        logic [31:0] press_tick[N_KEYS];
        logic [1:0]  class_q [N_KEYS];
        logic [15:0] long_ms;
        logic [7:0]  notify_mask;
        t_out_item   pending_events[$];
        int          errors;
        int          samples;
        int          events;
        int          long_reports;
        int          press_reports;

        function new();
            for (int k = 0; k < N_KEYS; k++) begin
                level_q[k]    = 1'b0;
                toggle_q[k]   = 1'b0;
                press_tick[k] = '0;
                class_q[k]    = CLS_RELEASE;
            end
            long_ms     = 16'd500;
            notify_mask = 8'd0;
        endfunction

        function void write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_LONG_PRESS_TIME)
                long_ms = value;
            else
                notify_mask = value[7:0];
        endfunction

        function void note_sample(t_in_item s);
            int          k;
            logic        now, last, rise, fall, en;
            logic [1:0]  cls;
            logic [31:0] held_ms;
            t_out_item   r;
            k    = int'(s.key_index);
            now  = s.key_level;
            r    = '0;
            r.key_echo = s.key_index;
            last = level_q[k];
            level_q[k] = now;
            rise = now && !last;
            fall = !now && last;
            cls  = class_q[k];
            if (rise) begin
                toggle_q[k]   = ~toggle_q[k];
                cls           = toggle_q[k] ? CLS_KEEP : CLS_CLICK;
                press_tick[k] = s.time_now;
            end
            // hold time wraps modulo 2^32
            held_ms = s.time_now - press_tick[k];
            if (fall)
                cls = (held_ms >= {16'd0, long_ms}) ? CLS_LONG : CLS_CLICK;
            if (now && held_ms >= {16'd0, long_ms})
                cls = CLS_LONG;
            en = notify_mask[k];
            r.rising_edge    = rise;
            r.falling_edge   = fall;
            r.toggle_state   = toggle_q[k];
            r.report_press   = en && rise;
            r.report_long    = en && !rise && (cls == CLS_LONG);
            r.report_release = en && fall;
            // a released key falls back to release after reporting
            if (!now)
                cls = CLS_RELEASE;
            class_q[k]    = cls;
            r.event_class = cls;
            pending_events.push_back(r);
            samples++;
        endfunction

        function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
            if (want_v !== got_v) begin
                errors++;
                if (errors < 60)
                    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name,
                             want_v, got_v);
            end
        endfunction

        function void check_event(t_out_item got);
            t_out_item want;
            if (pending_events.size() == 0) begin
                errors++;
                if (errors < 60)
                    $display("%0t ns: unexpected result, expected none, got %h", $time, got);
                return;
            end
            want = pending_events.pop_front();
            events++;
            if (got.report_long === 1'b1)
                long_reports++;
            if (got.report_press === 1'b1)
                press_reports++;
            compare_field("key_echo",       8'(want.key_echo),       8'(got.key_echo));
            compare_field("rising_edge",    8'(want.rising_edge),    8'(got.rising_edge));
            compare_field("falling_edge",   8'(want.falling_edge),   8'(got.falling_edge));
            compare_field("toggle_state",   8'(want.toggle_state),   8'(got.toggle_state));
            compare_field("event_class",    8'(want.event_class),    8'(got.event_class));
            compare_field("report_press",   8'(want.report_press),   8'(got.report_press));
            compare_field("report_long",    8'(want.report_long),    8'(got.report_long));
            compare_field("report_release", 8'(want.report_release), 8'(got.report_release));
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic                  i_cfg_idx  = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    key_event_checker sb;
    int               burst_left = 0;
    int               stall_tick = 0;
    int               idle_cycles = 0;
    int               cfg_writes = 0;
    logic [7:0]       key_held = '0;
    logic [31:0]      tick = '0;

    key_press_event_classifier #(.NUM_KEYS(N_KEYS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stall pattern steps through four modes: none, light random, periodic, heavy random
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case ((stall_tick / 97) % 4)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 99) < 30);
            end
            2: begin
                i_out_stall <= ((stall_tick % 5) < 2);
            end
            default: begin
                i_out_stall <= ($urandom_range(0, 99) < 70);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_event(o_out_data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_sample(logic [2:0] k, logic lvl, logic [31:0] t);
        t_in_item it;
        int       gap;
        it.key_index = k;
        it.key_level = lvl;
        it.time_now  = t;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(it);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [15:0] long_ms, logic [7:0] mask);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LONG_PRESS_TIME;
        i_cfg_data <= long_ms;
        @(negedge i_clk);
        sb.write_reg(CFG_LONG_PRESS_TIME, long_ms);
        i_cfg_idx  <= CFG_NOTIFY_ENABLE;
        i_cfg_data <= {8'd0, mask};
        @(negedge i_clk);
        sb.write_reg(CFG_NOTIFY_ENABLE, {8'd0, mask});
        i_cfg_we <= 1'b0;
        cfg_writes += 2;
        @(negedge i_clk);
    endtask

    // mostly press / hold / release runs per key, with some noise and tick jumps
    task automatic run_random(int n);
        int         step_max;
        int         r;
        logic [2:0] k;
        logic       lvl;
        step_max = int'(sb.long_ms) / 3 + 2;
        for (int i = 0; i < n; i++) begin
            k = 3'($urandom_range(0, N_KEYS - 1));
            r = $urandom_range(0, 99);
            if (r < 10)
                lvl = 1'($urandom_range(0, 1));
            else if (r < 45)
                lvl = ~key_held[k];
            else
                lvl = key_held[k];
            key_held[k] = lvl;
            r = $urandom_range(0, 99);
            if (r < 4)
                tick = $urandom;
            else if (r < 6)
                tick = 32'hFFFF_FFFF - $urandom_range(0, step_max * 4);
            else
                tick = tick + $urandom_range(0, step_max);
            send_sample(k, lvl, tick);
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: short click, long hold, idle release, reports masked
        send_sample(3'd0, 1'b1, 32'd0);
        send_sample(3'd0, 1'b1, 32'd100);
        send_sample(3'd0, 1'b0, 32'd200);
        send_sample(3'd7, 1'b1, 32'd1000);
        send_sample(3'd7, 1'b1, 32'd1600);
        send_sample(3'd7, 1'b0, 32'd1700);
        send_sample(3'd5, 1'b0, 32'd50);
        wait_drained();

        // all keys reporting; long hold across the tick wrap, second press of key 0
        set_config(16'd500, 8'hFF);
        send_sample(3'd3, 1'b1, 32'hFFFF_FF00);
        send_sample(3'd3, 1'b1, 32'h0000_0100);
        send_sample(3'd3, 1'b0, 32'h0000_0110);
        send_sample(3'd0, 1'b1, 32'd300);
        send_sample(3'd0, 1'b0, 32'd310);
        send_sample(3'd6, 1'b1, 32'hFFFF_FFFF);
        send_sample(3'd6, 1'b0, 32'hFFFF_FFFF);
        wait_drained();

        // zero threshold: every hold and release is long
        set_config(16'd0, 8'h5A);
        send_sample(3'd1, 1'b1, 32'd20);
        send_sample(3'd1, 1'b1, 32'd20);
        send_sample(3'd1, 1'b0, 32'd21);
        send_sample(3'd2, 1'b1, 32'd5);
        send_sample(3'd2, 1'b0, 32'd5);
        wait_drained();

        // largest threshold, one below and exactly at it
        set_config(16'hFFFF, 8'hFF);
        send_sample(3'd4, 1'b1, 32'h1000_0000);
        send_sample(3'd4, 1'b1, 32'h1000_FFFE);
        send_sample(3'd4, 1'b1, 32'h1000_FFFF);
        send_sample(3'd4, 1'b0, 32'h1001_1170);
        wait_drained();

        tick = $urandom;
        set_config(16'($urandom_range(100, 2000)), 8'($urandom_range(0, 255)));
        run_random(185);
        set_config(16'($urandom_range(0, 20)), 8'hFF);
        run_random(185);
        set_config(16'hFFFF, 8'($urandom_range(0, 255)));
        run_random(185);
        set_config(16'd500, 8'h00);
        run_random(185);

        if (sb.pending_events.size() != 0) begin
            sb.errors++;
            $display("%0t ns: %0d results never arrived", $time, sb.pending_events.size());
        end
        $display("Ran %0d key samples over %0d register writes, %0d results checked",
                 sb.samples, cfg_writes, sb.events);
        $display("Press reports seen: %0d, long press reports seen: %0d",
                 sb.press_reports, sb.long_reports);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
